// ===== src/gbn_pkg.sv =====
// Shared types and codes for the go-back-n client transport.
package gbn_pkg;

    // command codes
    localparam logic [2:0] CMD_CONNECT    = 3'd0;
    localparam logic [2:0] CMD_SEND       = 3'd1;
    localparam logic [2:0] CMD_DISCONNECT = 3'd2;
    localparam logic [2:0] CMD_RECEIVED   = 3'd3;
    localparam logic [2:0] CMD_TICK       = 3'd4;

    // received segment types
    localparam logic [2:0] RX_SYNACK  = 3'd1;
    localparam logic [2:0] RX_FINACK  = 3'd3;
    localparam logic [2:0] RX_DATAACK = 3'd5;

    // transmitted segment types
    localparam logic [1:0] TX_SYN  = 2'd0;
    localparam logic [1:0] TX_FIN  = 2'd1;
    localparam logic [1:0] TX_DATA = 2'd2;

    // status codes
    localparam logic [2:0] STAT_NONE         = 3'd0;
    localparam logic [2:0] STAT_CONNECTED    = 3'd1;
    localparam logic [2:0] STAT_CONN_FAILED  = 3'd2;
    localparam logic [2:0] STAT_CLOSED       = 3'd3;
    localparam logic [2:0] STAT_CLOSE_FAILED = 3'd4;
    localparam logic [2:0] STAT_OVERFLOW     = 3'd5;

    // configuration register indexes
    localparam logic [2:0] REG_CLIENT_PORT  = 3'd0;
    localparam logic [2:0] REG_SERVER_PORT  = 3'd1;
    localparam logic [2:0] REG_SYN_RETRY    = 3'd2;
    localparam logic [2:0] REG_FIN_RETRY    = 3'd3;
    localparam logic [2:0] REG_SYN_TIMEOUT  = 3'd4;
    localparam logic [2:0] REG_FIN_TIMEOUT  = 3'd5;
    localparam logic [2:0] REG_DATA_TIMEOUT = 3'd6;

    localparam int MAX_RESULTS = 8;

    typedef enum logic [1:0] {
        CONN_CLOSED, CONN_SYNSENT, CONN_CONNECTED, CONN_FINWAIT
    } t_conn;

    typedef enum logic [3:0] {
        SEQ_IDLE, SEQ_SPLIT, SEQ_ENQ, SEQ_ACK_RD, SEQ_ACK_CMP,
        SEQ_FILL_RD, SEQ_FILL_EMIT, SEQ_AGE_RD, SEQ_AGE_CMP,
        SEQ_RTX_RD, SEQ_RTX_EMIT, SEQ_EMIT1, SEQ_DONE
    } t_seq;

    // one result item
    typedef struct packed {
        logic        tx_valid;
        logic [1:0]  tx_type;
        logic [31:0] tx_seq;
        logic [10:0] tx_length;
        logic [15:0] tx_sport;
        logic [15:0] tx_dport;
        logic [2:0]  status;
    } t_result;

endpackage

// ===== src/gbn_desc_ram.sv =====
// Descriptor memory: sequence, length and sent time per queue entry.
module gbn_desc_ram
    import gbn_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int AW = 6
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wseq,
    input  logic [10:0]   i_wlen,
    input  logic [31:0]   i_wtime,
    input  logic          i_tw,
    input  logic [AW-1:0] i_twaddr,
    input  logic [31:0]   i_twtime,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rseq,
    output logic [10:0]   o_rlen,
    output logic [31:0]   o_rtime
);
    logic [31:0] r_seq  [QUEUE_DEPTH];
    logic [10:0] r_len  [QUEUE_DEPTH];
    logic [31:0] r_time [QUEUE_DEPTH];

    // seq/len store
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_seq[i_waddr] <= i_wseq;
            r_len[i_waddr] <= i_wlen;
        end
        o_rseq <= r_seq[i_raddr];
        o_rlen <= r_len[i_raddr];
    end

    // sent time store, written at enqueue or on (re)transmission
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_time[i_waddr] <= i_wtime;
        end else if (i_tw) begin
            r_time[i_twaddr] <= i_twtime;
        end
        o_rtime <= r_time[i_raddr];
    end
endmodule

// ===== src/go_back_n_client_transport.sv =====
// Go-back-n client transport: top level, sequencer and result register.
//
// One command is taken at a time; s_axis_tready stays low until the command
// has been worked through and its last result has been taken. A command that
// gives no result and walks no descriptor (ignored commands, handshake ticks
// that do not time out, ticks with nothing unacknowledged) stays in idle; a
// command with a single result (SYN, FIN, a status) passes through the
// single-result emit state. A send counts its descriptors by repeated
// subtraction of MAX_SEGMENT, writes the descriptors, then reads and emits
// each segment in turn. An overflowing send stops after the split (the split
// gives up once its count exceeds QUEUE_DEPTH). An ack reads and compares
// each freed entry, then reads and emits each newly sent segment. A data tick
// reads the oldest entry and checks its age, then reads and emits each resent
// segment. The sequencer walks one descriptor memory read port with one
// compare/add unit; while the result register waits on m_axis_tready, the
// next emit stalls.
module go_back_n_client_transport
    import gbn_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64,
    parameter int WINDOW = 8,
    parameter int MAX_SEGMENT = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // from bit 0: data_length[15:0], rx_type[2:0], rx_sport[15:0],
    // rx_ack_num[31:0], zero pad
    input  logic [71:0] s_axis_tdata,
    // command[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // from bit 0: tx_type[1:0], tx_seq[31:0], tx_length[10:0], tx_sport[15:0],
    // tx_dport[15:0], zero pad
    output logic [79:0] m_axis_tdata,
    // from bit 0: tx_valid, status[2:0]
    output logic [3:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
    localparam logic [CW-1:0] WIN_C   = CW'(WINDOW);
    localparam logic [15:0]   SEG_C   = 16'(MAX_SEGMENT);

    // configuration
    logic [15:0] r_client_port, r_server_port;
    logic [7:0]  r_syn_limit, r_fin_limit;
    logic [15:0] r_syn_to, r_fin_to, r_data_to;

    // protocol state
    t_conn         r_conn, n_conn;
    logic [31:0]   r_nseq, n_nseq;
    logic [AW-1:0] r_head, n_head, r_unsent, n_unsent, r_tail, n_tail;
    logic [CW-1:0] r_qcnt, n_qcnt, r_ucnt, n_ucnt;
    logic [7:0]    r_retry, n_retry;
    logic [15:0]   r_htimer, n_htimer;
    logic [31:0]   r_clock, n_clock;

    // sequencer
    t_seq          r_seq, n_seq;
    logic [15:0]   r_rem, n_rem;
    logic [15:0]   r_dlen, n_dlen;
    logic [CW-1:0] r_need, n_need, r_walk, n_walk;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [3:0]    r_nres, n_nres;
    logic [31:0]   r_ack, n_ack;
    t_result       r_one, n_one;

    // result register
    logic    r_ovalid, n_ovalid, r_olast, n_olast;
    t_result r_out, n_out;

    // memory ports
    logic          we, tw;
    logic [AW-1:0] raddr, twaddr;
    logic [10:0]   wlen;
    logic [31:0]   rseq, rtime;
    logic [10:0]   rlen;

    gbn_desc_ram #(.QUEUE_DEPTH(QUEUE_DEPTH), .AW(AW)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_tail), .i_wseq(r_nseq),
        .i_wlen(wlen), .i_wtime(r_clock), .i_tw(tw), .i_twaddr(twaddr),
        .i_twtime(r_clock), .i_raddr(raddr), .o_rseq(rseq), .o_rlen(rlen),
        .o_rtime(rtime)
    );

    function automatic logic [AW-1:0] wrap(input logic [AW-1:0] p);
        logic [AW:0] s;
        s = {1'b0, p} + 1'b1;
        return (s == (AW+1)'(QUEUE_DEPTH)) ? '0 : s[AW-1:0];
    endfunction

    function automatic t_result mk(input logic v, input logic [1:0] ty,
        input logic [31:0] sq, input logic [10:0] ln, input logic [2:0] st,
        input logic [15:0] cp, input logic [15:0] sp);
        t_result r;
        r.tx_valid = v;
        r.tx_type = v ? ty : 2'd0;
        r.tx_seq = v ? sq : 32'd0;
        r.tx_length = v ? ln : 11'd0;
        r.tx_sport = v ? cp : 16'd0;
        r.tx_dport = v ? sp : 16'd0;
        r.status = st;
        return r;
    endfunction

    logic [2:0]  cmd, rx_type;
    logic [15:0] dlen, rx_port;
    logic [31:0] rx_ack;
    assign cmd     = s_axis_tuser;
    assign dlen    = s_axis_tdata[15:0];
    assign rx_type = s_axis_tdata[18:16];
    assign rx_port = s_axis_tdata[34:19];
    assign rx_ack  = s_axis_tdata[66:35];

    logic in_acc, out_free, can_fill;
    assign s_axis_tready = (r_seq == SEQ_IDLE) && !r_ovalid;
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_ovalid || m_axis_tready;
    assign o_cfg_ready = 1'b1;
    assign can_fill = (r_ucnt < WIN_C) && (r_ucnt < r_qcnt)
                      && (r_nres < 4'(MAX_RESULTS));
    assign wlen = (r_rem >= SEG_C) ? 11'(SEG_C) : r_rem[10:0];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_client_port <= '0; r_server_port <= '0;
            r_syn_limit <= 8'd3; r_fin_limit <= 8'd3;
            r_syn_to <= 16'd100; r_fin_to <= 16'd100; r_data_to <= 16'd100;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CLIENT_PORT:  r_client_port <= i_cfg_data[15:0];
                REG_SERVER_PORT:  r_server_port <= i_cfg_data[15:0];
                REG_SYN_RETRY:    r_syn_limit <= i_cfg_data[7:0];
                REG_FIN_RETRY:    r_fin_limit <= i_cfg_data[7:0];
                REG_SYN_TIMEOUT:  r_syn_to <= i_cfg_data[15:0];
                REG_FIN_TIMEOUT:  r_fin_to <= i_cfg_data[15:0];
                REG_DATA_TIMEOUT: r_data_to <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conn <= CONN_CLOSED; r_nseq <= '0; r_head <= '0; r_unsent <= '0;
            r_tail <= '0; r_qcnt <= '0; r_ucnt <= '0; r_retry <= '0;
            r_htimer <= '0; r_clock <= '0; r_seq <= SEQ_IDLE; r_ovalid <= 1'b0;
            r_nres <= '0; r_olast <= 1'b0;
        end else begin
            r_conn <= n_conn; r_nseq <= n_nseq; r_head <= n_head;
            r_unsent <= n_unsent; r_tail <= n_tail; r_qcnt <= n_qcnt;
            r_ucnt <= n_ucnt; r_retry <= n_retry; r_htimer <= n_htimer;
            r_clock <= n_clock; r_seq <= n_seq; r_ovalid <= n_ovalid;
            r_nres <= n_nres; r_olast <= n_olast;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem; r_dlen <= n_dlen; r_need <= n_need; r_walk <= n_walk;
        r_ptr <= n_ptr; r_ack <= n_ack; r_one <= n_one; r_out <= n_out;
    end

    // sequencer
    always_comb begin
        n_conn = r_conn; n_nseq = r_nseq; n_head = r_head; n_unsent = r_unsent;
        n_tail = r_tail; n_qcnt = r_qcnt; n_ucnt = r_ucnt; n_retry = r_retry;
        n_htimer = r_htimer; n_clock = r_clock; n_seq = r_seq; n_rem = r_rem;
        n_dlen = r_dlen;
        n_need = r_need; n_walk = r_walk; n_ptr = r_ptr; n_nres = r_nres;
        n_ack = r_ack; n_one = r_one; n_out = r_out;
        n_ovalid = r_ovalid && !m_axis_tready; n_olast = r_olast;
        we = 1'b0; tw = 1'b0; raddr = r_ptr; twaddr = r_ptr;
        case (r_seq)
            SEQ_IDLE: begin
                n_nres = '0;
                if (in_acc) begin
                    n_seq = SEQ_IDLE;
                    case (cmd)
                        CMD_CONNECT: if (r_conn == CONN_CLOSED) begin
                            n_conn = CONN_SYNSENT; n_retry = '0; n_htimer = '0;
                            n_one = mk(1'b1, TX_SYN, '0, '0, STAT_NONE,
                                       r_client_port, r_server_port);
                            n_seq = SEQ_EMIT1;
                        end
                        CMD_SEND: if (r_conn == CONN_CONNECTED) begin
                            n_rem = dlen; n_dlen = dlen; n_need = '0; n_seq = SEQ_SPLIT;
                        end
                        CMD_DISCONNECT: if (r_conn == CONN_CONNECTED) begin
                            n_conn = CONN_FINWAIT; n_retry = '0; n_htimer = '0;
                            n_one = mk(1'b1, TX_FIN, '0, '0, STAT_NONE,
                                       r_client_port, r_server_port);
                            n_seq = SEQ_EMIT1;
                        end
                        CMD_RECEIVED: if (rx_port == r_server_port) begin
                            if (r_conn == CONN_SYNSENT && rx_type == RX_SYNACK) begin
                                n_conn = CONN_CONNECTED;
                                n_one = mk(1'b0, TX_SYN, '0, '0, STAT_CONNECTED,
                                           r_client_port, r_server_port);
                                n_seq = SEQ_EMIT1;
                            end else if (r_conn == CONN_CONNECTED
                                         && rx_type == RX_DATAACK) begin
                                n_ack = rx_ack; n_ptr = r_head; n_seq = SEQ_ACK_RD;
                            end else if (r_conn == CONN_FINWAIT
                                         && rx_type == RX_FINACK) begin
                                n_conn = CONN_CLOSED;
                                n_head = '0; n_unsent = '0; n_tail = '0;
                                n_qcnt = '0; n_ucnt = '0;
                                n_one = mk(1'b0, TX_SYN, '0, '0, STAT_CLOSED,
                                           r_client_port, r_server_port);
                                n_seq = SEQ_EMIT1;
                            end
                        end
                        CMD_TICK: begin
                            n_clock = r_clock + 32'd1;
                            if (r_conn == CONN_SYNSENT || r_conn == CONN_FINWAIT) begin
                                n_htimer = r_htimer + 16'd1;
                                if (n_htimer >= ((r_conn == CONN_SYNSENT) ? r_syn_to
                                                                           : r_fin_to)) begin
                                    n_htimer = '0;
                                    if (r_retry < ((r_conn == CONN_SYNSENT) ? r_syn_limit
                                                                             : r_fin_limit)) begin
                                        n_retry = r_retry + 8'd1;
                                        n_one = mk(1'b1, (r_conn == CONN_SYNSENT) ? TX_SYN
                                                   : TX_FIN, '0, '0, STAT_NONE,
                                                   r_client_port, r_server_port);
                                    end else begin
                                        n_one = mk(1'b0, TX_SYN, '0, '0,
                                                   (r_conn == CONN_SYNSENT) ?
                                                   STAT_CONN_FAILED : STAT_CLOSE_FAILED,
                                                   r_client_port, r_server_port);
                                        n_conn = CONN_CLOSED;
                                        n_head = '0; n_unsent = '0; n_tail = '0;
                                        n_qcnt = '0; n_ucnt = '0;
                                    end
                                    n_seq = SEQ_EMIT1;
                                end
                            end else if (r_conn == CONN_CONNECTED && r_ucnt != '0) begin
                                n_ptr = r_head; n_seq = SEQ_AGE_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // count descriptors by repeated subtraction of the segment size
            SEQ_SPLIT: begin
                if (r_rem == '0) begin
                    n_rem = r_dlen;
                    if (r_need > DEPTH_C - r_qcnt) begin
                        n_one = mk(1'b0, TX_SYN, '0, '0, STAT_OVERFLOW,
                                   r_client_port, r_server_port);
                        n_seq = SEQ_EMIT1;
                    end else begin
                        n_seq = SEQ_ENQ;
                    end
                end else begin
                    if (r_need > DEPTH_C) begin
                        n_rem = '0;
                    end else begin
                        n_rem = (r_rem >= SEG_C) ? r_rem - SEG_C : 16'd0;
                    end
                    n_need = r_need + 1'b1;
                end
            end
            SEQ_ENQ: begin
                if (r_rem == '0) begin
                    n_ptr = r_unsent; n_seq = SEQ_FILL_RD;
                end else begin
                    we = 1'b1;
                    n_nseq = r_nseq + {21'd0, wlen};
                    n_rem = r_rem - {5'd0, wlen};
                    n_tail = wrap(r_tail);
                    n_qcnt = r_qcnt + 1'b1;
                end
            end
            SEQ_ACK_RD: begin
                if (r_ucnt == '0) begin
                    n_ptr = r_unsent; n_seq = SEQ_FILL_RD;
                end else begin
                    n_seq = SEQ_ACK_CMP;
                end
            end
            SEQ_ACK_CMP: begin
                if (rseq < r_ack) begin
                    n_head = wrap(r_head); n_ptr = wrap(r_head);
                    n_ucnt = r_ucnt - 1'b1; n_qcnt = r_qcnt - 1'b1;
                    n_seq = SEQ_ACK_RD;
                end else begin
                    n_ptr = r_unsent; n_seq = SEQ_FILL_RD;
                end
            end
            SEQ_FILL_RD: begin
                if (can_fill) n_seq = SEQ_FILL_EMIT;
                else n_seq = SEQ_DONE;
            end
            SEQ_FILL_EMIT: begin
                if (out_free) begin
                    tw = 1'b1; twaddr = r_unsent;
                    n_unsent = wrap(r_unsent); n_ptr = wrap(r_unsent);
                    n_ucnt = r_ucnt + 1'b1; n_nres = r_nres + 1'b1;
                    n_out = mk(1'b1, TX_DATA, rseq, rlen, STAT_NONE,
                               r_client_port, r_server_port);
                    n_ovalid = 1'b1;
                    n_olast = !((n_ucnt < WIN_C) && (n_ucnt < r_qcnt)
                                && (n_nres < 4'(MAX_RESULTS)));
                    n_seq = n_olast ? SEQ_DONE : SEQ_FILL_RD;
                end
            end
            SEQ_AGE_RD: n_seq = SEQ_AGE_CMP;
            SEQ_AGE_CMP: begin
                if ((r_clock - rtime) < {16'd0, r_data_to}) begin
                    n_seq = SEQ_DONE;
                end else begin
                    n_walk = '0; n_seq = SEQ_RTX_RD;
                end
            end
            SEQ_RTX_RD: n_seq = SEQ_RTX_EMIT;
            SEQ_RTX_EMIT: begin
                if (out_free) begin
                    tw = 1'b1;
                    n_ptr = wrap(r_ptr); n_walk = r_walk + 1'b1;
                    n_nres = r_nres + 1'b1;
                    n_out = mk(1'b1, TX_DATA, rseq, rlen, STAT_NONE,
                               r_client_port, r_server_port);
                    n_ovalid = 1'b1;
                    n_olast = !((n_walk < r_ucnt) && (n_nres < 4'(MAX_RESULTS)));
                    n_seq = n_olast ? SEQ_DONE : SEQ_RTX_RD;
                end
            end
            SEQ_EMIT1: begin
                if (out_free) begin
                    n_out = r_one; n_ovalid = 1'b1; n_olast = 1'b1;
                    n_seq = SEQ_DONE;
                end
            end
            SEQ_DONE: begin
                // finish a walk that produced nothing or wait out the result
                if (!n_ovalid) n_seq = SEQ_IDLE;
            end
            default: n_seq = SEQ_IDLE;
        endcase
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {3'd0, r_out.tx_dport, r_out.tx_sport,
                            r_out.tx_length, r_out.tx_seq, r_out.tx_type};
    assign m_axis_tuser  = {r_out.status, r_out.tx_valid};

    // a result cannot be produced while the input side is open
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("ready while result pending");
    // unacked never exceeds queued
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ucnt <= r_qcnt)
        else $error("unacked count above queued count");
    // window holds
    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ucnt <= WIN_C)
        else $error("window exceeded");
endmodule
